>>> sv/nss7d_pkg.sv
// Shared types and constants for the nearest sample search block.
// Used by nss7d_ctrl, nss7d_dp and nearest_sample_search_7d; no dependencies.
`default_nettype none

package nss7d_pkg;

  localparam int unsigned IN_W   = 16;  // width of each component port
  localparam int unsigned N_IN   = 7;   // component ports on the input channel
  localparam int unsigned IDX_W  = 10;  // sample_index / nearest_index width
  localparam int unsigned CNT_W  = 11;  // sample_count register width
  localparam int unsigned DIST_W = 35;  // nearest_dist_sq width

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;   // store the input sample
    logic start;   // latch query, clear best, rewind scan
    logic rd_en;   // read the next sample row
    logic emit;    // move best into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // every row up to the count has been read
    logic pipe_busy;  // a sample is still in flight
    logic out_busy;   // output register holds a beat not yet taken
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> sv/nearest_sample_search_7d.sv
// Nearest sample search, top level. A load writes one store row.
// A query reads one row of all components per cycle from the sample store and queues
// its beat once the scan is done, the distance pipe has drained and the output is free.
// One query at a time: no further beat is taken until that query's result is queued;
// loads are taken back to back whenever no query is running.
// Reset clears sample_count and the control state; the store is left as is (no clear).
`default_nettype none

module nearest_sample_search_7d #(
  parameter int unsigned MAX_SAMPLES    = 1024,
  parameter int unsigned NUM_COMPONENTS = 7,
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [nss7d_pkg::CNT_W-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        req_type_i,
  input  wire logic [nss7d_pkg::IDX_W-1:0] sample_index_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_0_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_1_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_2_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_3_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_4_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_5_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]  comp_6_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [nss7d_pkg::IDX_W-1:0]      nearest_index_o,
  output logic [nss7d_pkg::DIST_W-1:0]     nearest_dist_sq_o
);
  import nss7d_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  nss7d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nss7d_dp #(
    .MAX_SAMPLES    (MAX_SAMPLES),
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .sample_index_i    (sample_index_i),
    .comp_0_i          (comp_0_i),
    .comp_1_i          (comp_1_i),
    .comp_2_i          (comp_2_i),
    .comp_3_i          (comp_3_i),
    .comp_4_i          (comp_4_i),
    .comp_5_i          (comp_5_i),
    .comp_6_i          (comp_6_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .nearest_index_o   (nearest_index_o),
    .nearest_dist_sq_o (nearest_dist_sq_o)
  );

  // a query blocks further input beats until its result is queued
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_QUERY)) |=> !in_ready_o)
    else $error("input taken during a query scan");

  // the result is only latched once every in-flight distance has been compared
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!sts.pipe_busy && !sts.out_busy))
    else $error("result emitted with the pipe busy or output full");

  // the scan never reads past the sample count
  a_no_overread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !sts.scan_done)
    else $error("row read beyond the sample count");

  // no store write while a scan is reading
  a_no_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> (!sts.pipe_busy && !cmd.rd_en))
    else $error("store written during a scan");

endmodule

`default_nettype wire

>>> sv/nss7d_ctrl.sv
// Sequencer for loads and query scans.
// Depends on nss7d_pkg; drives the command struct of nss7d_dp.
`default_nettype none

module nss7d_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                req_type_i,
  output logic                     in_ready_o,
  input  wire nss7d_pkg::ctrl_sts_t sts_i,
  output nss7d_pkg::ctrl_cmd_t     cmd_o
);
  import nss7d_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last distance to settle and the output slot to free up
        if (!sts_i.pipe_busy && !sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/nss7d_dp.sv
// Datapath: sample store, distance pipeline, best tracker, output register.
// Depends on nss7d_pkg; commanded by nss7d_ctrl.
`default_nettype none

module nss7d_dp #(
  parameter int unsigned MAX_SAMPLES    = 1024,
  parameter int unsigned NUM_COMPONENTS = 7,
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [nss7d_pkg::CNT_W-1:0]   cfg_data_i,
  input  wire nss7d_pkg::ctrl_cmd_t          cmd_i,
  output nss7d_pkg::ctrl_sts_t               sts_o,
  input  wire logic [nss7d_pkg::IDX_W-1:0]   sample_index_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_0_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_1_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_2_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_3_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_4_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_5_i,
  input  wire logic [nss7d_pkg::IN_W-1:0]    comp_6_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [nss7d_pkg::IDX_W-1:0]        nearest_index_o,
  output logic [nss7d_pkg::DIST_W-1:0]       nearest_dist_sq_o
);
  import nss7d_pkg::*;

  localparam int unsigned NC    = NUM_COMPONENTS;
  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned ROW_W = NC * CB;
  localparam int unsigned AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned NW    = (CNT_W > CW) ? CNT_W : CW;
  localparam int unsigned SQ_W  = 2 * CB;
  localparam int unsigned GRP   = (NC + 3) / 4;
  localparam int unsigned GW    = SQ_W + 2;
  localparam int unsigned SUM_W = SQ_W + 4;
  localparam logic [31:0] MAX32 = 32'(MAX_SAMPLES);

  // ---------------------------------------------------------------- inputs
  logic [IN_W-1:0] port_comp [N_IN];
  logic [CB-1:0]   in_val    [NC];

  assign port_comp[0] = comp_0_i;
  assign port_comp[1] = comp_1_i;
  assign port_comp[2] = comp_2_i;
  assign port_comp[3] = comp_3_i;
  assign port_comp[4] = comp_4_i;
  assign port_comp[5] = comp_5_i;
  assign port_comp[6] = comp_6_i;

  for (genvar c = 0; c < NC; c++) begin : g_inval
    if (c < N_IN) begin : g_port
      logic [IN_W+CB-1:0] ext;
      assign ext       = {{CB{1'b0}}, port_comp[c]};
      assign in_val[c] = ext[CB-1:0];
    end else begin : g_zero
      assign in_val[c] = '0;
    end
  end

  logic [ROW_W-1:0] wr_row;
  for (genvar c = 0; c < NC; c++) begin : g_pack
    assign wr_row[c*CB +: CB] = in_val[c];
  end

  // ------------------------------------------------------------ config reg
  logic [CNT_W-1:0] count_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // ------------------------------------------------------------ sample store
  logic [31:0]      slot32;
  logic             wr_ok;
  logic [AW-1:0]    rd_addr;
  logic [ROW_W-1:0] traj_q [MAX_SAMPLES];
  logic [ROW_W-1:0] row_q;

  assign slot32 = 32'(sample_index_i);
  assign wr_ok  = cmd_i.wr_en && (slot32 < MAX32);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      traj_q[slot32[AW-1:0]] <= wr_row;
    end
    if (cmd_i.rd_en) begin
      row_q <= traj_q[rd_addr];
    end
  end

  // ------------------------------------------------------- scan bookkeeping
  logic [NW-1:0] addr_q, n_q, n_d, cnt_ext;

  assign cnt_ext = NW'(count_q);
  assign n_d     = (cnt_ext > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : cnt_ext;
  assign rd_addr = addr_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      n_q    <= '0;
    end else if (cmd_i.start) begin
      addr_q <= '0;
      n_q    <= n_d;
    end else if (cmd_i.rd_en) begin
      addr_q <= addr_q + NW'(1);
    end
  end

  logic [CB-1:0] query_q [NC];
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q <= in_val;
    end
  end

  // --------------------------------------------------------- distance pipe
  // stage 1 row read, 2 abs diff, 3 square, 4 group sums, 5 total
  logic [4:0]    v_q;
  logic [AW-1:0] idx_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], cmd_i.rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= rd_addr;
    for (int i = 1; i < 5; i++) begin
      idx_q[i] <= idx_q[i-1];
    end
  end

  logic [CB-1:0]    diff_q [NC];
  logic [SQ_W-1:0]  sq_q   [NC];
  logic [GW-1:0]    grp_d  [GRP];
  logic [GW-1:0]    grp_q  [GRP];
  logic [SUM_W-1:0] sum_d, sum_q;

  for (genvar c = 0; c < NC; c++) begin : g_lane
    logic [CB-1:0] a;
    assign a = row_q[c*CB +: CB];
    always_ff @(posedge clk_i) begin
      diff_q[c] <= (a > query_q[c]) ? (a - query_q[c]) : (query_q[c] - a);
      sq_q[c]   <= SQ_W'(diff_q[c]) * SQ_W'(diff_q[c]);
    end
  end

  always_comb begin
    logic [GW-1:0] acc;
    for (int g = 0; g < GRP; g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < NC) begin
          acc = acc + GW'(sq_q[g*4+k]);
        end
      end
      grp_d[g] = acc;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < GRP; g++) begin
      sum_d = sum_d + SUM_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    sum_q <= sum_d;
  end

  // saturate to the output field width
  logic [SUM_W+DIST_W-1:0] sum_ext;
  logic [DIST_W-1:0]       cur_dist;

  assign sum_ext  = {{DIST_W{1'b0}}, sum_q};
  assign cur_dist = (sum_ext > (SUM_W+DIST_W)'(DIST_MAX)) ? DIST_MAX
                                                         : sum_ext[DIST_W-1:0];

  // ---------------------------------------------------------- best tracker
  // strict less-than keeps the earliest index on a tie
  logic [DIST_W-1:0] best_dist_q;
  logic [AW-1:0]     best_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      best_dist_q <= DIST_MAX;
      best_idx_q  <= '0;
    end else if (v_q[4] && (cur_dist < best_dist_q)) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= idx_q[4];
    end
  end

  // -------------------------------------------------------- output register
  logic [IDX_W+AW-1:0] best_idx_ext;
  logic                out_valid_q;

  assign best_idx_ext = {{IDX_W{1'b0}}, best_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      nearest_index_o   <= best_idx_ext[IDX_W-1:0];
      nearest_dist_sq_o <= best_dist_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.scan_done = (addr_q == n_q);
  assign sts_o.pipe_busy = |v_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire
